>>> rtl/url_percent_decoder_macros.svh
// Assertion helpers for the URL percent decoder.
`ifndef URL_PERCENT_DECODER_MACROS_SVH
`define URL_PERCENT_DECODER_MACROS_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define UPD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low.
`define UPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/upd_pkg.sv
package upd_pkg;

  typedef logic [7:0] byte_t;

  localparam byte_t CH_PCT   = 8'h25;  // '%'
  localparam byte_t CH_PLUS  = 8'h2B;  // '+'
  localparam byte_t CH_QUOT  = 8'h22;  // '"'
  localparam byte_t CH_SPACE = 8'h20;

  localparam int unsigned QUOT_LEN = 6;
  localparam byte_t QUOT_ENT [QUOT_LEN] = '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B};

  localparam int unsigned BURST_MAX = 8;
  localparam int unsigned BIDX_W    = $clog2(BURST_MAX);
  localparam int unsigned BCNT_W    = $clog2(BURST_MAX + 1);

  typedef logic [BIDX_W-1:0] bidx_t;
  typedef logic [BCNT_W-1:0] bcnt_t;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_PCT   = 3'b010,
    MODE_DIGIT = 3'b100
  } mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       string_end;
  } out_item_t;

  function automatic logic is_hex(input byte_t c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  // valid only for hex digits; letters have bit 6 set, low nibble 1..6
  function automatic logic [3:0] hex_val(input byte_t c);
    return c[6] ? (c[3:0] + 4'd9) : c[3:0];
  endfunction

endpackage

>>> rtl/upd_stream_if.sv
interface upd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/url_percent_decoder.sv
// Channel   Dir  Payload                            Transfer
// in_s      in   in_byte[7:0], in_last              valid & ready
// out_s     out  out_byte[7:0], run_end, string_end valid & ready
// cfg_s     in   escape_quotes (1 bit)              valid & ready, always ready
//
// An input byte is decoded in the cycle it is taken and its 0..8 result
// bytes land in a burst register, which drains one byte per cycle on out_s
// while out_s is ready. The next byte is taken in the same cycle as the
// last transfer of the previous burst, so plain bytes stream at one per
// cycle while out_s is ready. An item with no result leaves the burst empty.
// Reset (rst_n low at a clock edge) empties the burst and clears the decode
// state and escape_quotes. A stalled out_s holds the burst and backs up in_s.
`include "url_percent_decoder_macros.svh"

module url_percent_decoder
  import upd_pkg::*;
(
  input logic          clk,
  input logic          rst_n,
  upd_stream_if.sink   in_s,
  upd_stream_if.source out_s,
  upd_stream_if.sink   cfg_s
);

  // burst register: bytes, bytes left, read pointer, string-end tag
  byte_t  buf_r [BURST_MAX];
  bcnt_t  rem_r;
  bidx_t  idx_r;
  logic   strend_r;

  // decode state
  mode_t  mode_r, mode_nxt, mode_a;
  byte_t  held_r, held_nxt, held_a;
  logic   esc_r;

  logic   in_fire, out_fire;
  byte_t  b;
  logic   b_hex;

  // output slots in order: '%' prefix, held digit, value, '%' suffix, held digit
  logic   pre_pct, pre_held, val_en, suf_pct, suf_held;
  byte_t  val_byte;
  byte_t  bst [BURST_MAX];
  bcnt_t  bcnt;

  assign b     = in_s.data.in_byte;
  assign b_hex = is_hex(b);

  assign in_s.ready  = (rem_r == '0) || (out_s.ready && rem_r == bcnt_t'(1));
  assign in_fire     = in_s.valid && in_s.ready;
  assign out_s.valid = (rem_r != '0);
  assign out_fire    = out_s.valid && out_s.ready;

  assign out_s.data.out_byte   = buf_r[idx_r];
  assign out_s.data.run_end    = (rem_r == bcnt_t'(1));
  assign out_s.data.string_end = strend_r;

  assign cfg_s.ready = 1'b1;

  // decode step
  always_comb begin
    mode_a   = mode_r;
    held_a   = held_r;
    pre_pct  = 1'b0;
    pre_held = 1'b0;
    val_en   = 1'b0;
    val_byte = b;

    unique case (mode_r)
      MODE_PCT: begin
        if (b_hex) begin
          mode_a = MODE_DIGIT;
          held_a = b;
        end else begin
          pre_pct = 1'b1;
          mode_a  = MODE_IDLE;
        end
      end
      MODE_DIGIT: begin
        held_a = '0;
        mode_a = MODE_IDLE;
        if (b_hex) begin
          val_en   = 1'b1;
          val_byte = {hex_val(held_r), hex_val(b)};
        end else begin
          pre_pct  = 1'b1;
          pre_held = 1'b1;  // held byte is a hex digit, never '+' or '"'
        end
      end
      default: begin
        mode_a = MODE_IDLE;
      end
    endcase

    // plain byte path: idle, or a broken sequence falls back to it
    if (mode_a == MODE_IDLE && !val_en) begin
      if (b == CH_PCT) begin
        mode_a = MODE_PCT;
      end else begin
        val_en   = 1'b1;
        val_byte = (b == CH_PLUS) ? CH_SPACE : b;
      end
    end

    // end of string flushes whatever is still pending
    suf_pct  = in_s.data.in_last && (mode_a != MODE_IDLE);
    suf_held = in_s.data.in_last && (mode_a == MODE_DIGIT);
    if (in_s.data.in_last) begin
      mode_nxt = MODE_IDLE;
      held_nxt = '0;
    end else begin
      mode_nxt = mode_a;
      held_nxt = held_a;
    end
  end

  // pack the slots into the burst
  always_comb begin
    bcnt = '0;
    for (int i = 0; i < BURST_MAX; i++) begin
      bst[i] = '0;
    end
    if (pre_pct) begin
      bst[bcnt[BIDX_W-1:0]] = CH_PCT;
      bcnt = bcnt + bcnt_t'(1);
    end
    if (pre_held) begin
      bst[bcnt[BIDX_W-1:0]] = held_r;
      bcnt = bcnt + bcnt_t'(1);
    end
    if (val_en) begin
      if (esc_r && val_byte == CH_QUOT) begin
        for (int k = 0; k < QUOT_LEN; k++) begin
          bst[bcnt[BIDX_W-1:0] + bidx_t'(k)] = QUOT_ENT[k];
        end
        bcnt = bcnt + bcnt_t'(QUOT_LEN);
      end else begin
        bst[bcnt[BIDX_W-1:0]] = val_byte;
        bcnt = bcnt + bcnt_t'(1);
      end
    end
    if (suf_pct) begin
      bst[bcnt[BIDX_W-1:0]] = CH_PCT;
      bcnt = bcnt + bcnt_t'(1);
    end
    if (suf_held) begin
      bst[bcnt[BIDX_W-1:0]] = held_a;
      bcnt = bcnt + bcnt_t'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      idx_r  <= '0;
      mode_r <= MODE_IDLE;
      held_r <= '0;
      esc_r  <= 1'b0;
    end else begin
      if (cfg_s.valid) begin
        esc_r <= cfg_s.data;
      end
      if (in_fire) begin
        rem_r  <= bcnt;
        idx_r  <= '0;
        mode_r <= mode_nxt;
        held_r <= held_nxt;
      end else if (out_fire) begin
        rem_r <= rem_r - bcnt_t'(1);
        idx_r <= idx_r + bidx_t'(1);
      end
    end
  end

  // burst payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      buf_r    <= bst;
      strend_r <= in_s.data.in_last;
    end
  end

  // a new burst only overwrites an empty or just-finished one
  `UPD_ASSERT_SAME(a_no_overwrite, in_fire, rem_r == '0 || (rem_r == bcnt_t'(1) && out_s.ready), "burst overwritten before drained")
  // held digit is only meaningful while a digit is pending
  `UPD_ASSERT_SAME(a_held_clear, mode_r != MODE_DIGIT, held_r == '0, "stale held digit")
  // end of string leaves nothing pending
  `UPD_ASSERT_NEXT(a_flush_on_last, in_fire && in_s.data.in_last, mode_r == MODE_IDLE, "sequence pending after last byte")
  // burst never exceeds the buffer
  `UPD_ASSERT_SAME(a_burst_bound, in_fire, bcnt <= bcnt_t'(BURST_MAX), "burst too long")

endmodule

>>> sim/url_percent_decoder_test.sv
module url_percent_decoder_test
  import upd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Longest stretch without any transfer before the run is declared hung.
  // The deliberate receiver hold-off is HOLD_OFF_CYCLES, far below this.
  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  // Settle margin after the last expected byte, so that a byte with no result
  // is fully taken before a register write or the end of the run.
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned STALL_HEAVY     = 84;
  localparam int unsigned STALL_LIGHT     = 10;

  // Scoreboard: mirrors the decoder state and keeps the bytes it must emit.
  class percent_decode_scoreboard;
    out_item_t   decoded_q[$];
    byte_t       burst[$];
    logic        quote_escape = 1'b0;
    mode_t       pend_mode    = MODE_IDLE;
    byte_t       pend_digit   = '0;
    int unsigned errors       = 0;
    int unsigned n_in         = 0;
    int unsigned n_out        = 0;
    int unsigned n_entities   = 0;
    int unsigned n_decoded    = 0;
    int unsigned n_broken     = 0;
    int unsigned max_burst    = 0;

    static function bit is_hex_char(byte_t c);
      return (c >= "0" && c <= "9") || ((c | 8'h20) >= "a" && (c | 8'h20) <= "f");
    endfunction

    // Folding to lower case puts 'a'..'f' at 0x61..0x66, i.e. 10..15 above 0x57.
    static function logic [3:0] nibble_of(byte_t c);
      if (c <= "9")
        return c[3:0];
      return 4'((c | 8'h20) - 8'h57);
    endfunction

    function void add_byte(byte_t b);
      burst.insert(burst.size(), b);
    endfunction

    function void emit_value(byte_t b);
      if (quote_escape && b == CH_QUOT) begin
        for (int k = 0; k < QUOT_LEN; k++)
          add_byte(QUOT_ENT[k]);
        n_entities++;
      end else begin
        add_byte(b);
      end
    endfunction

    // only a literal plus becomes a space, never a decoded one
    function void emit_literal(byte_t b);
      if (b == CH_PLUS)
        add_byte(CH_SPACE);
      else
        emit_value(b);
    endfunction

    function void take_plain(byte_t b);
      if (b == CH_PCT)
        pend_mode = MODE_PCT;
      else
        emit_literal(b);
    endfunction

    function void write_config(logic v);
      quote_escape = v;
    endfunction

    function int unsigned pending();
      return decoded_q.size();
    endfunction

    function void take_encoded(in_item_t it);
      byte_t     b;
      out_item_t res;
      b = it.in_byte;
      n_in++;
      burst.delete();
      case (pend_mode)
        MODE_PCT: begin
          if (is_hex_char(b)) begin
            pend_digit = b;
            pend_mode  = MODE_DIGIT;
          end else begin
            // broken right after the percent sign
            add_byte(CH_PCT);
            n_broken++;
            pend_mode = MODE_IDLE;
            take_plain(b);
          end
        end
        MODE_DIGIT: begin
          if (is_hex_char(b)) begin
            emit_value({nibble_of(pend_digit), nibble_of(b)});
            n_decoded++;
          end else begin
            add_byte(CH_PCT);
            emit_literal(pend_digit);
            n_broken++;
            pend_mode = MODE_IDLE;
            take_plain(b);
          end
          if (pend_mode == MODE_DIGIT)
            pend_mode = MODE_IDLE;
          pend_digit = '0;
        end
        default: begin
          pend_mode = MODE_IDLE;
          take_plain(b);
        end
      endcase
      // string end flushes whatever escape is still open
      if (it.in_last) begin
        if (pend_mode != MODE_IDLE)
          add_byte(CH_PCT);
        if (pend_mode == MODE_DIGIT)
          emit_literal(pend_digit);
        pend_mode  = MODE_IDLE;
        pend_digit = '0;
      end
      if (burst.size() > max_burst)
        max_burst = burst.size();
      foreach (burst[k]) begin
        res = '{out_byte: burst[k], run_end: (k == burst.size() - 1),
                string_end: it.in_last};
        decoded_q.insert(decoded_q.size(), res);
      end
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %02h, actual %02h", field, want, got);
        errors++;
      end
    endfunction

    function void check_decoded(out_item_t got);
      out_item_t want;
      n_out++;
      if (decoded_q.size() == 0) begin
        $error("out_byte %02h transferred with nothing expected", got.out_byte);
        errors++;
        return;
      end
      want = decoded_q.pop_front();
      compare_field("out_byte", want.out_byte, got.out_byte);
      compare_field("run_end", 8'(want.run_end), 8'(got.run_end));
      compare_field("string_end", 8'(want.string_end), 8'(got.string_end));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  upd_stream_if #(.payload_t(in_item_t))  in_if ();
  upd_stream_if #(.payload_t(out_item_t)) out_if ();
  upd_stream_if #(.payload_t(logic))      cfg_if ();

  url_percent_decoder dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_if),
    .out_s (out_if),
    .cfg_s (cfg_if)
  );

  percent_decode_scoreboard sb = new();

  // Knobs shared between the stimulus and the receiver.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req       = 1'b0;
  int unsigned hold_offs      = 0;
  int unsigned bytes_sent     = 0;
  int unsigned cfg_writes     = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Transfers are sampled at the edge; all drivers use nonblocking updates,
  // so what is read here is the pre-edge value of every signal.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready)
        sb.write_config(cfg_if.data);
      if (in_if.valid && in_if.ready)
        sb.take_encoded(in_if.data);
      if (out_if.valid && out_if.ready)
        sb.check_decoded(out_if.data);
    end
  end

  // Receiver: random stalls, plus one long hold-off on request so the burst
  // register fills and the input side backs up.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
        hold_offs++;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: ends the run when no transfer of any kind happens for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $error("no transfer for %0d cycles, %0d results outstanding", QUIET_LIMIT, sb.pending());
    $display("FAIL url_percent_decoder");
    $finish;
  end

  // One input transfer, with random idle cycles ahead of it. valid is only
  // lowered in cycles where no item is offered, never dropped and re-raised
  // within the same step.
  task automatic send_byte(input byte_t b, input logic is_end);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= '{in_byte: b, in_last: is_end};
    do @(posedge clk); while (!in_if.ready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input bit end_flag);
    for (int k = 0; k < s.len(); k++)
      send_byte(byte_t'(s[k]), end_flag && (k == s.len() - 1));
  endtask

  function automatic byte_t rand_hex();
    int unsigned v;
    v = $urandom_range(15);
    if (v < 10)
      return byte_t'(8'h30 + v);
    return byte_t'(($urandom_range(1) ? 8'h61 : 8'h41) + v - 10);
  endfunction

  function automatic byte_t rand_nonhex();
    byte_t b;
    do b = byte_t'($urandom_range(255)); while (percent_decode_scoreboard::is_hex_char(b));
    return b;
  endfunction

  // Mostly well-formed text: plain bytes, plus signs, quotes and valid escapes,
  // with some broken escapes and escapes cut off by the end of the string.
  task automatic send_random_string();
    byte_t       seq[$];
    int unsigned pick;
    repeat ($urandom_range(1, 8)) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        seq.insert(seq.size(), byte_t'($urandom_range(255)));
      end else if (pick < 40) begin
        seq.insert(seq.size(), CH_PLUS);
      end else if (pick < 50) begin
        seq.insert(seq.size(), CH_QUOT);
      end else if (pick < 80) begin
        seq.insert(seq.size(), CH_PCT);
        if ($urandom_range(4) == 0) begin
          // escaped double quote
          seq.insert(seq.size(), byte_t'("2"));
          seq.insert(seq.size(), byte_t'("2"));
        end else begin
          seq.insert(seq.size(), rand_hex());
          seq.insert(seq.size(), rand_hex());
        end
      end else begin
        seq.insert(seq.size(), CH_PCT);
        if ($urandom_range(1))
          seq.insert(seq.size(), rand_hex());
        if ($urandom_range(2) != 0)
          seq.insert(seq.size(), rand_nonhex());
      end
    end
    foreach (seq[k])
      send_byte(seq[k], k == seq.size() - 1);
  endtask

  // Wait until every expected byte has come out, then a short settle margin.
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_escape(input logic v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input bit hold_off, input int unsigned budget);
    int unsigned start;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start          = bytes_sent;
    if (hold_off)
      hold_req = 1'b1;
    while (bytes_sent - start < budget)
      send_random_string();
    drain();
  endtask

  initial begin : stimulus
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, escaping off: byte extremes, literal plus, escaped plus kept
    // as plus, non-ASCII pass-through.
    send_byte(8'h00, 1'b0);
    send_text("+%2B", 1'b0);
    send_byte(8'hFF, 1'b1);
    // broken after '%' (by a quote), broken after one digit, '%' breaking
    // '%' and starting a new escape, lower-case hex
    send_text("%\"%4g%%6f", 1'b1);
    // string ends with a digit pending, then with only '%' pending
    send_text("%a", 1'b1);
    send_text("%", 1'b1);
    drain();

    // Directed, escaping on: literal and decoded quotes, and a broken escape
    // with digit ahead of a quote, the eight-byte worst case.
    write_escape(1'b1);
    send_text("\"%22%2\"", 1'b1);
    drain();

    run_phase(0, 0, 1'b0, 14);
    write_escape(1'b0);
    run_phase(STALL_HEAVY, 0, 1'b0, 12);
    write_escape(1'b1);
    run_phase(0, STALL_HEAVY, 1'b0, 12);
    write_escape(1'b0);
    run_phase(STALL_LIGHT, STALL_LIGHT, 1'b0, 12);
    // back-pressure: receiver holds off while the sender keeps offering
    write_escape(1'b1);
    run_phase(0, 0, 1'b1, 14);

    $display("Decoded %0d input bytes into %0d output bytes across %0d register writes,",
             sb.n_in, sb.n_out, cfg_writes);
    $display("with %0d escapes, %0d broken escapes, %0d quote entities,",
             sb.n_decoded, sb.n_broken, sb.n_entities);
    $display("burst up to %0d, %0d hold-offs.", sb.max_burst, hold_offs);
    if (sb.errors == 0)
      $display("PASS url_percent_decoder");
    else
      $display("FAIL url_percent_decoder");
    $finish;
  end

endmodule
